// ===== hw/rtl/vctl_pkg.sv =====
// ----------------------------------------------------------------------------
// vctl_pkg: shared definitions for the virtual cpuid answer table
// table geometry, entry layout, status codes and register indexes
// ----------------------------------------------------------------------------
package vctl_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int WORD_W      = 32;
  localparam int CFG_IDX_W   = 8;
  localparam int IN_DATA_W   = 200;  // 193 field bits padded to whole bytes
  localparam int OUT_DATA_W  = 128;

  localparam logic [CFG_IDX_W-1:0] REG_STD_LEVEL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EXT_LEVEL = CFG_IDX_W'(1);

  localparam logic [WORD_W-1:0] STD_LEVEL_RST = 32'h0000_0000;
  localparam logic [WORD_W-1:0] EXT_LEVEL_RST = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LEAF_EXT_BIT  = 32'h8000_0000;

  // per-cpu leaves, never served from the table
  localparam logic [WORD_W-1:0] LEAF_FEATURES = 32'h0000_0001;
  localparam logic [WORD_W-1:0] LEAF_TOPOLOGY = 32'h0000_000b;
  localparam logic [WORD_W-1:0] LEAF_XSTATE   = 32'h0000_000d;

  typedef enum logic [0:0] {
    ACT_INSERT = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_MISS     = 3'd1,
    ST_INSERTED = 3'd2,
    ST_FULL     = 3'd3,
    ST_PERCPU   = 3'd4
  } status_t;

  typedef struct packed {
    logic [WORD_W-1:0] edx;
    logic [WORD_W-1:0] ecx;
    logic [WORD_W-1:0] ebx;
    logic [WORD_W-1:0] eax;
    logic              check;
    logic [WORD_W-1:0] subleaf;
    logic [WORD_W-1:0] leaf;
  } entry_t;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] edx;
    logic [WORD_W-1:0] ecx;
    logic [WORD_W-1:0] ebx;
    logic [WORD_W-1:0] eax;
  } result_t;

endpackage

// ===== hw/rtl/virtual_cpuid_table_lookup.sv =====
// ----------------------------------------------------------------------------
// virtual_cpuid_table_lookup
// table of virtual cpuid answers: insert at the end and leaf/subleaf search
// ----------------------------------------------------------------------------
// insert, per-cpu and empty-table beats: the result is registered in the holding stage, then in the output register.
// lookup: one table entry per cycle from a simple dual-port synchronous memory;
//   each scan reads the middle entry, picks its start, then steps forward,
//   and the scan runs a second time when the fallback retry runs.
// one item at a time; a finished result waits in a holding stage.
// reset empties the table and loads the level registers; memory is not cleared.
module virtual_cpuid_table_lookup (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // config write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [vctl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vctl_pkg::WORD_W-1:0]          cfg_data,
  // input beats
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // leaf, subleaf, check_subleaf, entry_eax, entry_ebx, entry_ecx, entry_edx
  input  logic [vctl_pkg::IN_DATA_W-1:0]       in_tdata,
  // action
  input  logic [0:0]                           in_tuser,
  // result beats
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // res_eax, res_ebx, res_ecx, res_edx
  output logic [vctl_pkg::OUT_DATA_W-1:0]      out_tdata,
  // status
  output logic [2:0]                           out_tuser
);

  localparam int IDX_W = vctl_pkg::IDX_W;
  localparam int CNT_W = vctl_pkg::CNT_W;
  localparam int WW    = vctl_pkg::WORD_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_HALF  = 4'b0100,
    S_SCAN  = 4'b1000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [CNT_W-1:0]           k_r, k_nxt;
  logic [WW-1:0]              std_level_r, ext_level_r;
  logic [WW-1:0]              leaf_r, leaf_nxt;
  logic [WW-1:0]              tgt_r, tgt_nxt;
  logic [WW-1:0]              sub_r, sub_nxt;
  logic                       retry_r, retry_nxt;
  logic                       pend_r, pend_nxt;
  vctl_pkg::result_t          pend_res_r, pend_res_nxt;
  logic                       out_valid_r;
  vctl_pkg::result_t          out_res_r;

  vctl_pkg::entry_t           mem [vctl_pkg::TABLE_DEPTH];
  vctl_pkg::entry_t           rd_data_r;
  vctl_pkg::entry_t           in_entry;
  logic [IDX_W-1:0]           rd_addr;
  logic                       wr_en;

  logic                       in_acc;
  logic                       out_load;
  logic                       is_percpu;
  logic [CNT_W-1:0]           half;
  logic [CNT_W-1:0]           start_k;
  logic [WW-1:0]              limit;
  logic                       table_full;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE) && !pend_r;
  assign in_acc    = in_tvalid && in_tready;

  assign in_entry.leaf    = in_tdata[31:0];
  assign in_entry.subleaf = in_tdata[63:32];
  assign in_entry.check   = in_tdata[64];
  assign in_entry.eax     = in_tdata[96:65];
  assign in_entry.ebx     = in_tdata[128:97];
  assign in_entry.ecx     = in_tdata[160:129];
  assign in_entry.edx     = in_tdata[192:161];

  assign is_percpu  = (in_entry.leaf == vctl_pkg::LEAF_FEATURES) ||
                      (in_entry.leaf == vctl_pkg::LEAF_TOPOLOGY) ||
                      (in_entry.leaf == vctl_pkg::LEAF_XSTATE);
  assign table_full = (cnt_r == CNT_W'(vctl_pkg::TABLE_DEPTH));
  assign half       = cnt_r >> 1;
  assign start_k    = (rd_data_r.leaf < tgt_r) ? half : '0;
  assign limit      = ((leaf_r & vctl_pkg::LEAF_EXT_BIT) != '0) ? ext_level_r : std_level_r;
  assign wr_en      = in_acc && (vctl_pkg::action_t'(in_tuser) == vctl_pkg::ACT_INSERT) &&
                      !table_full;

  // read address: middle entry, then the chosen start, then one ahead of the scan
  always_comb begin
    case (state_r)
      S_START: rd_addr = IDX_W'(half);
      S_HALF:  rd_addr = IDX_W'(start_k);
      S_SCAN:  rd_addr = IDX_W'(k_r + CNT_W'(1));
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[IDX_W'(cnt_r)] <= in_entry;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    k_nxt        = k_r;
    leaf_nxt     = leaf_r;
    tgt_nxt      = tgt_r;
    sub_nxt      = sub_r;
    retry_nxt    = retry_r;
    pend_nxt     = pend_r && !out_load;
    pend_res_nxt = pend_res_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pend_res_nxt = '0;
          if (vctl_pkg::action_t'(in_tuser) == vctl_pkg::ACT_INSERT) begin
            pend_nxt = 1'b1;
            if (table_full) begin
              pend_res_nxt.status = vctl_pkg::ST_FULL;
            end else begin
              pend_res_nxt.status = vctl_pkg::ST_INSERTED;
              cnt_nxt             = cnt_r + CNT_W'(1);
            end
          end else if (is_percpu) begin
            pend_nxt            = 1'b1;
            pend_res_nxt.status = vctl_pkg::ST_PERCPU;
          end else if (cnt_r == '0) begin
            // empty table misses on both tries
            pend_nxt            = 1'b1;
            pend_res_nxt.status = vctl_pkg::ST_MISS;
          end else begin
            leaf_nxt  = in_entry.leaf;
            tgt_nxt   = in_entry.leaf;
            sub_nxt   = in_entry.subleaf;
            retry_nxt = 1'b0;
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        state_nxt = S_HALF;
      end
      S_HALF: begin
        k_nxt     = start_k;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if ((k_r < cnt_r) &&
            ((rd_data_r.leaf < tgt_r) ||
             ((rd_data_r.leaf == tgt_r) && rd_data_r.check &&
              (rd_data_r.subleaf != sub_r)))) begin
          k_nxt = k_r + CNT_W'(1);
        end else if ((k_r < cnt_r) && (rd_data_r.leaf == tgt_r)) begin
          pend_nxt            = 1'b1;
          pend_res_nxt.status = vctl_pkg::ST_FOUND;
          pend_res_nxt.eax    = rd_data_r.eax;
          pend_res_nxt.ebx    = rd_data_r.ebx;
          pend_res_nxt.ecx    = rd_data_r.ecx;
          pend_res_nxt.edx    = rd_data_r.edx;
          state_nxt           = S_IDLE;
        end else if (!retry_r && (leaf_r > limit)) begin
          // out of range: search once more with the standard limit as leaf
          tgt_nxt   = std_level_r;
          retry_nxt = 1'b1;
          state_nxt = S_START;
        end else begin
          pend_nxt            = 1'b1;
          pend_res_nxt.status = vctl_pkg::ST_MISS;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_load = pend_r && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      std_level_r <= vctl_pkg::STD_LEVEL_RST;
      ext_level_r <= vctl_pkg::EXT_LEVEL_RST;
      retry_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      retry_r <= retry_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == vctl_pkg::REG_STD_LEVEL) begin
          std_level_r <= cfg_data;
        end else if (cfg_index == vctl_pkg::REG_EXT_LEVEL) begin
          ext_level_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    leaf_r     <= leaf_nxt;
    tgt_r      <= tgt_nxt;
    sub_r      <= sub_nxt;
    pend_res_r <= pend_res_nxt;
    if (out_load) begin
      out_res_r <= pend_res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {out_res_r.edx, out_res_r.ecx, out_res_r.ebx, out_res_r.eax};

  // a held result only exists while the sequencer is idle
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_IDLE))
    else $error("result pending while a search runs");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(vctl_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (k_r <= cnt_r))
    else $error("scan index beyond entry count");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("insert did not advance entry count");

  a_single_retry: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && (state_nxt == S_START)) |-> !retry_r)
    else $error("second retry started");

endmodule
